// ===== hw/rtl/murmur3_word_stream_hash_top_assert.svh =====
// Assertion macros shared by the checker of the word stream hash block.
`ifndef MURMUR3_WORD_STREAM_HASH_TOP_ASSERT_SVH
`define MURMUR3_WORD_STREAM_HASH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWSH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MWSH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mwsh_pkg.sv =====
package mwsh_pkg;

    localparam int WORD_W = 32;
    localparam int COUNT_W = 3;

    localparam logic [WORD_W-1:0] MUR_C1 = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] MUR_C2 = 32'h1b873593;
    localparam logic [WORD_W-1:0] MUR_N = 32'he6546b64;
    localparam logic [WORD_W-1:0] MUR_F1 = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] MUR_F2 = 32'hc2b2ae35;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'd5381;

    localparam logic [COUNT_W-1:0] FULL_BYTES = 3'd4;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [WORD_W-1:0] k;
        logic [COUNT_W-1:0] nbytes;
        logic full;
        logic last;
    } entry_t;

    function automatic logic [WORD_W-1:0] mix_block(
        input logic [WORD_W-1:0] h,
        input logic [WORD_W-1:0] k
    );
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] r;
        begin
            x = h ^ k;
            r = {x[WORD_W-14:0], x[WORD_W-1:WORD_W-13]};
            return (r << 2) + r + MUR_N;
        end
    endfunction

endpackage

// ===== hw/rtl/mwsh_word_if.sv =====
interface mwsh_word_if;
    logic valid;
    logic ready;
    logic [mwsh_pkg::WORD_W-1:0] data_word;
    logic [mwsh_pkg::COUNT_W-1:0] byte_count;
    logic last_word;

    modport source(output valid, output data_word, output byte_count, output last_word,
                   input ready);
    modport sink(input valid, input data_word, input byte_count, input last_word,
                 output ready);
endinterface

// ===== hw/rtl/mwsh_hash_if.sv =====
interface mwsh_hash_if;
    logic valid;
    logic ready;
    logic [mwsh_pkg::WORD_W-1:0] hash_value;

    modport source(output valid, output hash_value, input ready);
    modport sink(input valid, input hash_value, output ready);
endinterface

// ===== hw/rtl/murmur3_word_stream_hash_top.sv =====
// A last word passes front stages s1, s2, the queue and back-end states MIX, AV1, AV2.
// Throughput: one word per cycle when nothing stalls, set by the running-hash update;
// a last word holds the back end in AV1 and AV2 while the two avalanche multiplies run.
// Reset: rst_n is asynchronous and active low; it loads the seed 5381, clears the
// byte total and empties the front pipeline, the queue and the output register.
module murmur3_word_stream_hash_top
#(
    parameter int QUEUE_DEPTH = mwsh_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    mwsh_word_if.sink word_ch,
    mwsh_hash_if.source hash_ch,
    input  logic cfg_we,
    input  logic [mwsh_pkg::WORD_W-1:0] cfg_wdata
);

    logic push_valid;
    logic push_ready;
    mwsh_pkg::entry_t push_entry;
    logic pop_valid;
    logic pop_ready;
    mwsh_pkg::entry_t pop_entry;
    logic in_ready;
    logic out_valid;
    logic [mwsh_pkg::WORD_W-1:0] out_hash;

    assign word_ch.ready = in_ready;
    assign hash_ch.valid = out_valid;
    assign hash_ch.hash_value = out_hash;

    mwsh_front u_front
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(word_ch.valid),
        .in_ready(in_ready),
        .data_word(word_ch.data_word),
        .byte_count(word_ch.byte_count),
        .last_word(word_ch.last_word),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_entry(push_entry)
    );

    mwsh_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue
    (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_entry(push_entry),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_entry(pop_entry)
    );

    mwsh_back u_back
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_entry(pop_entry),
        .out_valid(out_valid),
        .out_ready(hash_ch.ready),
        .out_hash(out_hash)
    );

endmodule

// ===== hw/rtl/mwsh_front.sv =====
module mwsh_front
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [mwsh_pkg::WORD_W-1:0] data_word,
    input  logic [mwsh_pkg::COUNT_W-1:0] byte_count,
    input  logic last_word,
    output logic push_valid,
    input  logic push_ready,
    output mwsh_pkg::entry_t push_entry
);

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    mwsh_pkg::entry_t s1_reg;
    mwsh_pkg::entry_t s1_next;
    mwsh_pkg::entry_t s2_reg;
    mwsh_pkg::entry_t s2_next;
    logic s1_adv;
    logic s2_adv;
    logic [mwsh_pkg::COUNT_W-1:0] nbytes;
    logic [mwsh_pkg::WORD_W-1:0] mask;
    logic [mwsh_pkg::WORD_W-1:0] rot;

    assign s2_adv = !s2_valid_reg || push_ready;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;
    assign push_valid = s2_valid_reg;
    assign push_entry = s2_reg;

    // A word that is not the last one always counts as four bytes.
    always_comb
    begin
        if (!last_word || byte_count >= mwsh_pkg::FULL_BYTES)
        begin
            nbytes = mwsh_pkg::FULL_BYTES;
        end
        else
        begin
            nbytes = byte_count;
        end
        case (nbytes)
            3'd0: mask = 32'h00000000;
            3'd1: mask = 32'h000000ff;
            3'd2: mask = 32'h0000ffff;
            3'd3: mask = 32'h00ffffff;
            default: mask = 32'hffffffff;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next = s1_reg;
        s2_valid_next = s2_valid_reg;
        s2_next = s2_reg;
        rot = {s1_reg.k[mwsh_pkg::WORD_W-16:0], s1_reg.k[mwsh_pkg::WORD_W-1:mwsh_pkg::WORD_W-15]};
        if (s1_adv)
        begin
            s1_valid_next = in_valid;
            s1_next.k = (data_word & mask) * mwsh_pkg::MUR_C1;
            s1_next.nbytes = nbytes;
            s1_next.full = (nbytes == mwsh_pkg::FULL_BYTES);
            s1_next.last = last_word;
        end
        if (s2_adv)
        begin
            s2_valid_next = s1_valid_reg;
            s2_next.k = rot * mwsh_pkg::MUR_C2;
            s2_next.nbytes = s1_reg.nbytes;
            s2_next.full = s1_reg.full;
            s2_next.last = s1_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

endmodule

// ===== hw/rtl/mwsh_queue.sv =====
module mwsh_queue
#(
    parameter int DEPTH = mwsh_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  mwsh_pkg::entry_t push_entry,
    output logic pop_valid,
    input  logic pop_ready,
    output mwsh_pkg::entry_t pop_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mwsh_pkg::entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slots_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/mwsh_back.sv =====
module mwsh_back
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [mwsh_pkg::WORD_W-1:0] cfg_wdata,
    input  logic pop_valid,
    output logic pop_ready,
    input  mwsh_pkg::entry_t pop_entry,
    output logic out_valid,
    input  logic out_ready,
    output logic [mwsh_pkg::WORD_W-1:0] out_hash
);

    localparam logic [1:0] ST_MIX = 2'd0;
    localparam logic [1:0] ST_AV1 = 2'd1;
    localparam logic [1:0] ST_AV2 = 2'd2;

    localparam int W = mwsh_pkg::WORD_W;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [W-1:0] seed_reg;
    logic [W-1:0] seed_next;
    logic [W-1:0] hash_reg;
    logic [W-1:0] hash_next;
    logic [W-1:0] total_reg;
    logic [W-1:0] total_next;
    logic [W-1:0] fin_reg;
    logic [W-1:0] fin_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic [W-1:0] out_hash_reg;
    logic [W-1:0] out_hash_next;
    logic [W-1:0] mixed;
    logic [W-1:0] tail;
    logic [W-1:0] prod;
    logic out_free;

    assign out_valid = out_valid_reg;
    assign out_hash = out_hash_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == ST_MIX) && !cfg_we;

    always_comb
    begin
        state_next = state_reg;
        seed_next = seed_reg;
        hash_next = hash_reg;
        total_next = total_reg;
        fin_next = fin_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_hash_next = out_hash_reg;
        mixed = mwsh_pkg::mix_block(hash_reg, pop_entry.k);
        tail = pop_entry.full ? mixed : (hash_reg ^ pop_entry.k);
        prod = (fin_reg ^ (fin_reg >> 13)) * mwsh_pkg::MUR_F2;
        if (cfg_we)
        begin
            // A seed write drops a key being mixed.
            seed_next = cfg_wdata;
            hash_next = cfg_wdata;
            total_next = '0;
        end
        else
        begin
            case (state_reg)
                ST_MIX:
                begin
                    if (pop_valid)
                    begin
                        if (pop_entry.last)
                        begin
                            fin_next = tail ^ (total_reg + W'(pop_entry.nbytes));
                            hash_next = seed_reg;
                            total_next = '0;
                            state_next = ST_AV1;
                        end
                        else
                        begin
                            hash_next = mixed;
                            total_next = total_reg + W'(mwsh_pkg::FULL_BYTES);
                        end
                    end
                end
                ST_AV1:
                begin
                    fin_next = (fin_reg ^ (fin_reg >> 16)) * mwsh_pkg::MUR_F1;
                    state_next = ST_AV2;
                end
                ST_AV2:
                begin
                    if (out_free)
                    begin
                        out_hash_next = prod ^ (prod >> 16);
                        out_valid_next = 1'b1;
                        state_next = ST_MIX;
                    end
                end
                default:
                begin
                    state_next = ST_MIX;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MIX;
            seed_reg <= mwsh_pkg::SEED_RESET;
            hash_reg <= mwsh_pkg::SEED_RESET;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg <= seed_next;
            hash_reg <= hash_next;
            total_reg <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
        out_hash_reg <= out_hash_next;
    end

endmodule

// ===== hw/rtl/mwsh_checker.sv =====
`include "murmur3_word_stream_hash_top_assert.svh"

module mwsh_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic [mwsh_pkg::WORD_W-1:0] out_hash
);

    logic [15:0] pending_reg;
    logic [15:0] pending_next;
    logic key_done;
    logic hash_taken;

    assign key_done = in_valid && in_ready && in_last;
    assign hash_taken = out_valid && out_ready;

    // Count of finished keys whose hash has not been taken yet.
    always_comb
    begin
        pending_next = pending_reg;
        if (key_done && !hash_taken)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (hash_taken && !key_done)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `MWSH_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_hash), "result changed while stalled")
    `MWSH_ASSERT_NOW(a_no_spurious, out_valid, pending_reg != 16'd0, "result without a finished key")
    `MWSH_ASSERT_NEXT(a_min_latency, key_done && (pending_reg == 16'd0) && !out_valid, !out_valid, "result appeared too early")

endmodule

bind murmur3_word_stream_hash_top mwsh_checker u_mwsh_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(word_ch.valid),
    .in_ready(word_ch.ready),
    .in_last(word_ch.last_word),
    .out_valid(hash_ch.valid),
    .out_ready(hash_ch.ready),
    .out_hash(hash_ch.hash_value)
);
